>>> rtl/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg: shared types and constants of the state variable filter
// Widths, register indexes, datapath commands and the saturation helper.
// ----------------------------------------------------------------------------
package svf_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_FRAC_DEF    = 16;

	localparam int STATE_W    = 32;
	localparam int COEF_W     = 24;
	localparam int MIX_W      = 17;
	localparam int MIX_FRAC   = 16;
	localparam int MODE_W     = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int PROD_W     = COEF_W + 1 + STATE_W;
	localparam int SUM_W      = PROD_W + 1;

	localparam logic signed [SUM_W-1:0] S32_MAX =
		{{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] S32_MIN =
		{{(SUM_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_ALPHA0  = 3'd1,
		REG_ALPHA   = 3'd2,
		REG_RHO     = 3'd3,
		REG_AUX_MIX = 3'd4
	} reg_idx_t;

	// codes above the band-stop blend pass the sample through
	typedef enum logic [MODE_W-1:0] {
		MODE_LP = 3'd0,
		MODE_HP = 3'd1,
		MODE_BP = 3'd2,
		MODE_BS = 3'd3
	} mode_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_RHO_Z1,
		MUL_A0_E,
		MUL_G_HP,
		MUL_G_BP,
		MUL_MIX_HP,
		MUL_MIXC_LP
	} mul_op_t;

	typedef enum logic [3:0] {
		ACC_NONE,
		ACC_E,
		ACC_HP,
		ACC_BP,
		ACC_Z1,
		ACC_LP,
		ACC_Z2,
		ACC_BS0,
		ACC_BS1
	} acc_op_t;

	typedef enum logic [2:0] {
		OUT_LP,
		OUT_HP,
		OUT_BP,
		OUT_BS,
		OUT_X
	} out_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PASS,
		ST_MUL_E,
		ST_ACC_E,
		ST_MUL_HP,
		ST_ACC_HP,
		ST_MUL_BP,
		ST_ACC_BP,
		ST_ACC_Z1,
		ST_ACC_LP,
		ST_ACC_Z2,
		ST_BS0,
		ST_BS1,
		ST_OUT
	} svf_state_t;

	typedef struct packed {
		logic     load_x;
		mul_op_t  mul;
		acc_op_t  acc;
		logic     load_out;
		out_sel_t out_sel;
	} svf_cmd_t;

	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (v > S32_MAX) begin
			r = S32_MAX;
		end else if (v < S32_MIN) begin
			r = S32_MIN;
		end
		return r[STATE_W-1:0];
	endfunction

endpackage

>>> rtl/svf_in_if.sv
// ----------------------------------------------------------------------------
// svf_in_if: input sample channel
// Valid/ready channel carrying one audio sample per transfer.
// ----------------------------------------------------------------------------
interface svf_in_if
	import svf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

>>> rtl/svf_out_if.sv
// ----------------------------------------------------------------------------
// svf_out_if: output sample channel
// Valid/ready channel carrying one filtered sample per transfer.
// ----------------------------------------------------------------------------
interface svf_out_if
	import svf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

>>> rtl/svf_datapath.sv
// ----------------------------------------------------------------------------
// svf_datapath: filter arithmetic
// One shared coefficient multiplier with a product register, a rounding
// add-and-saturate unit, the integrator states and the output register.
// ----------------------------------------------------------------------------
module svf_datapath
	import svf_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  svf_cmd_t                       cmd,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic        [COEF_W-1:0]       coef_alpha0,
	input  logic        [COEF_W-1:0]       coef_alpha,
	input  logic        [COEF_W-1:0]       coef_rho,
	input  logic        [MIX_W-1:0]        aux_mix,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0]  BS_HALF  = SUM_W'(1) << (MIX_FRAC - 1);
	localparam logic        [MIX_W-1:0]  MIX_ONE  = MIX_W'(1) << MIX_FRAC;
	localparam logic signed [STATE_W:0]  SMAX     =
		(STATE_W+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [STATE_W:0]  SMIN     = -SMAX - (STATE_W+1)'(1);

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [STATE_W:0]        d_q;
	logic signed [STATE_W-1:0]      z1_q, z2_q, e_q, hp_q, bp_q, lp_q, bs_q;
	logic signed [PROD_W-1:0]       prod_q, bs_acc_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;

	logic        [MIX_W-1:0]        mix, mixc;
	logic        [COEF_W-1:0]       mul_c;
	logic signed [STATE_W-1:0]      mul_v;
	logic signed [PROD_W-1:0]       prod_d, rnd;
	logic signed [SUM_W-1:0]        addend, acc_sum, bs_sum, bs_res;
	logic signed [STATE_W-1:0]      acc_res, out_src;
	logic signed [STATE_W:0]        out_ext;
	logic signed [SAMPLE_WIDTH-1:0] out_d;

	assign mix  = (aux_mix > MIX_ONE) ? MIX_ONE : aux_mix;
	assign mixc = MIX_ONE - mix;

	// shared multiplier operands
	always_comb begin
		mul_c = '0;
		mul_v = '0;
		unique case (cmd.mul)
			MUL_NONE: begin
			end
			MUL_RHO_Z1: begin
				mul_c = coef_rho;
				mul_v = z1_q;
			end
			MUL_A0_E: begin
				mul_c = coef_alpha0;
				mul_v = e_q;
			end
			MUL_G_HP: begin
				mul_c = coef_alpha;
				mul_v = hp_q;
			end
			MUL_G_BP: begin
				mul_c = coef_alpha;
				mul_v = bp_q;
			end
			MUL_MIX_HP: begin
				mul_c = COEF_W'(mix);
				mul_v = hp_q;
			end
			MUL_MIXC_LP: begin
				mul_c = COEF_W'(mixc);
				mul_v = lp_q;
			end
			default: begin
			end
		endcase
	end

	assign prod_d = $signed({1'b0, mul_c}) * mul_v;

	// round to nearest, tie toward plus infinity
	assign rnd = (prod_q + RND_HALF) >>> COEF_FRAC_BITS;

	always_comb begin
		addend = '0;
		unique case (cmd.acc)
			ACC_E:   addend = SUM_W'(d_q);
			ACC_BP:  addend = SUM_W'(z1_q);
			ACC_Z1:  addend = SUM_W'(bp_q);
			ACC_LP:  addend = SUM_W'(z2_q);
			ACC_Z2:  addend = SUM_W'(lp_q);
			default: addend = '0;
		endcase
	end

	assign acc_sum = (cmd.acc == ACC_E) ? addend - SUM_W'(rnd) : addend + SUM_W'(rnd);
	assign acc_res = sat32(acc_sum);

	// band-stop blend, a convex mix so it stays in the state range
	assign bs_sum = SUM_W'(bs_acc_q) + SUM_W'(prod_q) + BS_HALF;
	assign bs_res = bs_sum >>> MIX_FRAC;

	always_comb begin
		unique case (cmd.out_sel)
			OUT_LP:  out_src = lp_q;
			OUT_HP:  out_src = hp_q;
			OUT_BP:  out_src = bp_q;
			OUT_BS:  out_src = bs_q;
			OUT_X:   out_src = STATE_W'(x_q);
			default: out_src = STATE_W'(x_q);
		endcase
	end

	assign out_ext = (STATE_W+1)'(out_src);

	always_comb begin
		if (out_ext > SMAX) begin
			out_d = SMAX[SAMPLE_WIDTH-1:0];
		end else if (out_ext < SMIN) begin
			out_d = SMIN[SAMPLE_WIDTH-1:0];
		end else begin
			out_d = out_src[SAMPLE_WIDTH-1:0];
		end
	end

	// integrator states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q <= '0;
			z2_q <= '0;
		end else begin
			if (cmd.acc == ACC_Z1) begin
				z1_q <= acc_res;
			end
			if (cmd.acc == ACC_Z2) begin
				z2_q <= acc_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= sample_in;
			d_q <= (STATE_W+1)'(sample_in) - (STATE_W+1)'(z2_q);
		end
		if (cmd.mul != MUL_NONE) begin
			prod_q <= prod_d;
		end
		unique case (cmd.acc)
			ACC_E:   e_q <= acc_res;
			ACC_HP:  hp_q <= acc_res;
			ACC_BP:  bp_q <= acc_res;
			ACC_LP:  lp_q <= acc_res;
			ACC_BS0: bs_acc_q <= prod_q;
			ACC_BS1: bs_q <= bs_res[STATE_W-1:0];
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	assign sample_out = out_q;

endmodule

>>> rtl/svf_ctrl.sv
// ----------------------------------------------------------------------------
// svf_ctrl: filter sequencer
// Steps the datapath through one sample and owns the channel handshakes.
// ----------------------------------------------------------------------------
module svf_ctrl
	import svf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  logic [MODE_W-1:0] mode,
	output logic              in_ready,
	output logic              out_valid,
	output svf_cmd_t          cmd
);

	svf_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (mode > MODE_BS) ? ST_PASS : ST_MUL_E;
				end
			end
			ST_PASS: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL_E:  state_d = ST_ACC_E;
			ST_ACC_E:  state_d = ST_MUL_HP;
			ST_MUL_HP: state_d = ST_ACC_HP;
			ST_ACC_HP: state_d = ST_MUL_BP;
			ST_MUL_BP: state_d = ST_ACC_BP;
			ST_ACC_BP: state_d = ST_ACC_Z1;
			ST_ACC_Z1: state_d = ST_ACC_LP;
			ST_ACC_LP: state_d = ST_ACC_Z2;
			ST_ACC_Z2: state_d = ST_BS0;
			ST_BS0:    state_d = ST_BS1;
			ST_BS1:    state_d = ST_OUT;
			ST_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.load_x   = 1'b0;
		cmd.mul      = MUL_NONE;
		cmd.acc      = ACC_NONE;
		cmd.load_out = 1'b0;
		cmd.out_sel  = OUT_X;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.load_x = in_valid;
			end
			ST_PASS: begin
				cmd.load_out = slot_free;
			end
			ST_MUL_E:  cmd.mul = MUL_RHO_Z1;
			ST_ACC_E:  cmd.acc = ACC_E;
			ST_MUL_HP: cmd.mul = MUL_A0_E;
			ST_ACC_HP: cmd.acc = ACC_HP;
			ST_MUL_BP: cmd.mul = MUL_G_HP;
			ST_ACC_BP: cmd.acc = ACC_BP;
			ST_ACC_Z1: begin
				cmd.acc = ACC_Z1;
				cmd.mul = MUL_G_BP;
			end
			ST_ACC_LP: cmd.acc = ACC_LP;
			ST_ACC_Z2: begin
				cmd.acc = ACC_Z2;
				cmd.mul = MUL_MIX_HP;
			end
			ST_BS0: begin
				cmd.acc = ACC_BS0;
				cmd.mul = MUL_MIXC_LP;
			end
			ST_BS1:    cmd.acc = ACC_BS1;
			ST_OUT: begin
				cmd.load_out = slot_free;
				unique case (mode)
					MODE_LP: cmd.out_sel = OUT_LP;
					MODE_HP: cmd.out_sel = OUT_HP;
					MODE_BP: cmd.out_sel = OUT_BP;
					default: cmd.out_sel = OUT_BS;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/state_variable_filter_2pole.sv
// ----------------------------------------------------------------------------
// state_variable_filter_2pole: two-pole state variable filter
// The filter modes step each sample through the multiply and accumulate
// states; passthrough loads the sample straight into the output register.
// A new sample is taken only once the previous one is loaded for output,
// as the single shared coefficient multiplier serves all six products of
// a sample, and a held output delays that load.
// Reset clears the integrators and loads the register defaults.
// ----------------------------------------------------------------------------
module state_variable_filter_2pole
	import svf_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	svf_in_if.sink                x_chan,
	svf_out_if.source             y_chan,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
	localparam logic [MIX_W-1:0]  MIX_HALF = MIX_W'(1) << (MIX_FRAC - 1);

	logic [MODE_W-1:0] mode_q;
	logic [COEF_W-1:0] alpha0_q, alpha_q, rho_q;
	logic [MIX_W-1:0]  mix_q;
	svf_cmd_t          cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LP;
			alpha0_q <= COEF_ONE;
			alpha_q  <= COEF_ONE;
			rho_q    <= COEF_ONE;
			mix_q    <= MIX_HALF;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:    mode_q   <= wr_data[MODE_W-1:0];
				REG_ALPHA0:  alpha0_q <= wr_data[COEF_W-1:0];
				REG_ALPHA:   alpha_q  <= wr_data[COEF_W-1:0];
				REG_RHO:     rho_q    <= wr_data[COEF_W-1:0];
				REG_AUX_MIX: mix_q    <= wr_data[MIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	svf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (x_chan.valid),
		.out_ready (y_chan.ready),
		.mode      (mode_q),
		.in_ready  (x_chan.ready),
		.out_valid (y_chan.valid),
		.cmd       (cmd)
	);

	svf_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_in   (x_chan.sample_in),
		.coef_alpha0 (alpha0_q),
		.coef_alpha  (alpha_q),
		.coef_rho    (rho_q),
		.aux_mix     (mix_q),
		.sample_out  (y_chan.sample_out)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(x_chan.valid && x_chan.ready) |=> !x_chan.ready)
		else $error("input taken while a sample is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!y_chan.valid || y_chan.ready))
		else $error("output register overwritten before transfer");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc == ACC_Z1 || cmd.acc == ACC_Z2) |-> (mode_q <= MODE_BS))
		else $error("integrator updated in passthrough mode");

endmodule

>>> tb/tb_state_variable_filter_2pole.sv
// ----------------------------------------------------------------------------
// tb_state_variable_filter_2pole: self-checking bench for the two-pole SVF
// Drives samples through the input channel and sets the mode, coefficient
// and mix registers between runs of traffic while the filter is idle.
// A built-in fixed-point model of the filter predicts each output sample,
// and every output transfer is compared in order against it. Directed
// cases cover each mode, the passthrough codes, extreme coefficients and
// mix values, and full-scale samples. Random phases then use realistic
// and unrestricted coefficient sets under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_state_variable_filter_2pole;
	import svf_pkg::*;

	localparam int SW         = SAMPLE_WIDTH_DEF;
	localparam int COEF_FRAC  = COEF_FRAC_DEF;
	localparam int LATENCY    = 16;
	localparam int RANDOM_PHASES     = 10;
	localparam int ITEMS_PER_PHASE   = 95;

	localparam logic [MODE_W-1:0]    MODE_PASS_LO = 3'd4;
	localparam logic [MODE_W-1:0]    MODE_PASS_HI = 3'd7;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED   = 3'd7;

	localparam logic [COEF_W-1:0] COEF_UNITY = 24'd65536;
	localparam logic [COEF_W-1:0] COEF_MAX   = 24'hFFFFFF;
	localparam logic [MIX_W-1:0]  MIX_MAX    = 17'h1FFFF;
	localparam longint            MIX_UNITY  = 65536;

	localparam longint ROUND_COEF = longint'(1) <<< (COEF_FRAC - 1);
	localparam longint S32_HI     = 64'sd2147483647;
	localparam longint S32_LO     = -64'sd2147483648;
	localparam longint SAMPLE_HI  = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint SAMPLE_LO  = -(longint'(1) <<< (SW - 1));

	localparam logic signed [SW-1:0] SAMPLE_MAX = SAMPLE_HI[SW-1:0];
	localparam logic signed [SW-1:0] SAMPLE_MIN = SAMPLE_LO[SW-1:0];

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [REG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	svf_in_if  #(.SAMPLE_WIDTH(SW)) x_chan ();
	svf_out_if #(.SAMPLE_WIDTH(SW)) y_chan ();

	state_variable_filter_2pole #(
		.SAMPLE_WIDTH   (SW),
		.COEF_FRAC_BITS (COEF_FRAC)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.x_chan   (x_chan),
		.y_chan   (y_chan),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// filter model state and register copies
	logic [MODE_W-1:0] cfg_mode   = MODE_LP;
	logic [COEF_W-1:0] cfg_alpha0 = COEF_UNITY;
	logic [COEF_W-1:0] cfg_alpha  = COEF_UNITY;
	logic [COEF_W-1:0] cfg_rho    = COEF_UNITY;
	logic [MIX_W-1:0]  cfg_mix    = 17'd32768;
	int                integ_one  = 0;
	int                integ_two  = 0;

	logic signed [SW-1:0] pending_outputs[$];
	logic signed [SW-1:0] want_out;
	logic signed [SW-1:0] last_sample = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int failures        = 0;
	int samples_sent    = 0;
	int results_checked = 0;
	int settings_used   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint coef_scale(input logic [COEF_W-1:0] c, input int v);
		return (longint'(c) * longint'(v) + ROUND_COEF) >>> COEF_FRAC;
	endfunction

	function automatic int clamp32(input longint v);
		if (v > S32_HI) return int'(S32_HI);
		if (v < S32_LO) return int'(S32_LO);
		return int'(v);
	endfunction

	function automatic logic signed [SW-1:0] clamp_sample(input longint v);
		longint r;
		r = v;
		if (r > SAMPLE_HI) r = SAMPLE_HI;
		if (r < SAMPLE_LO) r = SAMPLE_LO;
		return r[SW-1:0];
	endfunction

	// one filter step: returns the output and, outside passthrough, advances both integrators
	function automatic logic signed [SW-1:0] filter_response(input logic signed [SW-1:0] x);
		int     e, hp, bp, lp;
		longint mix, blend, chosen;
		if (cfg_mode > MODE_BS) return x;
		e  = clamp32(longint'(x) - coef_scale(cfg_rho, integ_one) - longint'(integ_two));
		hp = clamp32(coef_scale(cfg_alpha0, e));
		bp = clamp32(coef_scale(cfg_alpha, hp) + longint'(integ_one));
		lp = clamp32(coef_scale(cfg_alpha, bp) + longint'(integ_two));
		integ_one = clamp32(coef_scale(cfg_alpha, hp) + longint'(bp));
		integ_two = clamp32(coef_scale(cfg_alpha, bp) + longint'(lp));
		mix = (cfg_mix > MIX_UNITY) ? MIX_UNITY : longint'(cfg_mix);
		blend = (mix * longint'(hp) + (MIX_UNITY - mix) * longint'(lp)
			+ (MIX_UNITY >>> 1)) >>> MIX_FRAC;
		case (cfg_mode)
			MODE_LP: chosen = lp;
			MODE_HP: chosen = hp;
			MODE_BP: chosen = bp;
			default: chosen = blend;
		endcase
		return clamp_sample(chosen);
	endfunction

	// output side: random backpressure and in-order compare
	always @(posedge clk) begin
		y_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && y_chan.valid && y_chan.ready) begin
			if (pending_outputs.size() == 0) begin
				$error("sample_out transfer with nothing expected: actual %0d",
					y_chan.sample_out);
				failures++;
			end else begin
				want_out = pending_outputs.pop_front();
				results_checked++;
				if (y_chan.sample_out !== want_out) begin
					$error("sample_out: expected %0d, actual %0d", want_out,
						y_chan.sample_out);
					failures++;
				end
			end
		end
	end

	task automatic send_sample(input logic signed [SW-1:0] x);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 20);
		if (gap > 0) begin
			x_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		x_chan.valid     <= 1'b1;
		x_chan.sample_in <= x;
		do @(posedge clk); while (!x_chan.ready);
		pending_outputs.push_back(filter_response(x));
		last_sample = x;
		samples_sent++;
	endtask

	task automatic drain_outputs();
		x_chan.valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_MODE:    cfg_mode   = value[MODE_W-1:0];
			REG_ALPHA0:  cfg_alpha0 = value[COEF_W-1:0];
			REG_ALPHA:   cfg_alpha  = value[COEF_W-1:0];
			REG_RHO:     cfg_rho    = value[COEF_W-1:0];
			REG_AUX_MIX: cfg_mix    = value[MIX_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		drain_outputs();
		settings_used++;
		write_register(REG_MODE, CFG_DATA_W'(m));
	endtask

	function automatic logic signed [SW-1:0] rand_sample();
		int k, near_zero;
		k = $urandom_range(0, 9);
		near_zero = int'($urandom_range(0, 8191)) - 4096;
		if (k < 6) return SW'($urandom);
		if (k < 8) return near_zero[SW-1:0];
		if (k == 8) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
		return last_sample;
	endfunction

	task automatic test_default_settings();
		send_sample(SAMPLE_MAX);
		send_sample('0);
		send_sample(SAMPLE_MIN);
		send_sample(SW'(1));
	endtask

	task automatic test_each_mode();
		logic [MODE_W-1:0] modes[6];
		modes = '{MODE_LP, MODE_HP, MODE_BP, MODE_BS, MODE_PASS_LO, MODE_PASS_HI};
		foreach (modes[i]) begin
			set_mode(modes[i]);
			send_sample(SAMPLE_MAX);
			send_sample(SAMPLE_MIN);
		end
	endtask

	task automatic test_extremes();
		// writes to an unassigned index must not disturb anything
		drain_outputs();
		write_register(REG_UNUSED, '1);
		write_register(REG_ALPHA0, COEF_MAX);
		write_register(REG_ALPHA, COEF_MAX);
		write_register(REG_RHO, COEF_MAX);
		set_mode(MODE_HP);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		drain_outputs();
		write_register(REG_ALPHA0, '0);
		write_register(REG_ALPHA, '0);
		write_register(REG_RHO, '0);
		set_mode(MODE_LP);
		send_sample(SAMPLE_MIN);
		drain_outputs();
		write_register(REG_ALPHA0, COEF_UNITY);
		write_register(REG_ALPHA, 24'd20000);
		write_register(REG_RHO, 24'd60000);
		write_register(REG_AUX_MIX, CFG_DATA_W'(MIX_MAX));
		set_mode(MODE_BS);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		drain_outputs();
		write_register(REG_AUX_MIX, '0);
		send_sample(SAMPLE_MAX);
	endtask

	task automatic test_random();
		longint                g, two_r, rho, a0;
		logic [CFG_DATA_W-1:0] mode_word;
		logic [MODE_W-1:0]     m;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase < 3) begin
				send_idle_pct = 9;  recv_stall_pct = 45;
			end else if (phase < 6) begin
				send_idle_pct = 45; recv_stall_pct = 9;
			end else begin
				send_idle_pct = 0;  recv_stall_pct = 0;
			end
			drain_outputs();
			settings_used++;
			if ($urandom_range(0, 4) == 0)
				m = MODE_W'($urandom_range(32'(MODE_PASS_LO), 32'(MODE_PASS_HI)));
			else
				m = MODE_W'($urandom_range(32'(MODE_LP), 32'(MODE_BS)));
			mode_word = CFG_DATA_W'($urandom);
			mode_word[MODE_W-1:0] = m;
			write_register(REG_MODE, mode_word);
			if (phase % 4 == 3) begin
				write_register(REG_ALPHA0, CFG_DATA_W'($urandom_range(0, 32'(COEF_MAX))));
				write_register(REG_ALPHA, CFG_DATA_W'($urandom_range(0, 32'(COEF_MAX))));
				write_register(REG_RHO, CFG_DATA_W'($urandom_range(0, 32'(COEF_MAX))));
			end else begin
				// tuned coefficients: a0 = 1 / (1 + g * (2R + g))
				g     = longint'($urandom_range(500, 262144));
				two_r = longint'($urandom_range(0, 131072));
				rho   = two_r + g;
				a0    = (longint'(1) <<< 32) / (MIX_UNITY + ((g * rho) >>> COEF_FRAC));
				write_register(REG_ALPHA0, a0[CFG_DATA_W-1:0]);
				write_register(REG_ALPHA, g[CFG_DATA_W-1:0]);
				write_register(REG_RHO, rho[CFG_DATA_W-1:0]);
			end
			if ($urandom_range(0, 7) == 0)
				write_register(REG_AUX_MIX, CFG_DATA_W'($urandom_range(
					32'(MIX_UNITY + 1), 32'(MIX_MAX))));
			else
				write_register(REG_AUX_MIX, CFG_DATA_W'($urandom_range(0, 32'(MIX_UNITY))));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(rand_sample());
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		x_chan.valid     = 1'b0;
		x_chan.sample_in = '0;
		y_chan.ready     = 1'b0;
		send_idle_pct    = 9;
		recv_stall_pct   = 45;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_each_mode();
		test_extremes();
		test_random();

		drain_outputs();
		if (pending_outputs.size() != 0) begin
			$error("%0d expected samples never came out", pending_outputs.size());
			failures++;
		end
		$display("%0d samples sent over %0d register settings, %0d outputs checked",
			samples_sent, settings_used, results_checked);
		$display("all modes, passthrough codes, extreme coefficients and mix values covered");
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
